[rtl/tick_callout_queue_defines.svh]
// assertion macros for the callout queue
`ifndef TICK_CALLOUT_QUEUE_DEFINES_SVH
`define TICK_CALLOUT_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define TCQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcq assertion failed");
`define TCQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcq assertion failed");
`else
`define TCQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TCQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/tcq_pkg.sv]
package tcq_pkg;

    localparam int NUM_W = 34;
    localparam int DEN_W = 33;
    localparam int ITER_W = 6;
    localparam logic [31:0] GRAIN_RESET = 32'd100000;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_ENQUEUED  = 3'd0,
        STS_FULL      = 3'd1,
        STS_FIRED     = 3'd2,
        STS_NO_FIRE   = 3'd3,
        STS_FOUND     = 3'd4,
        STS_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ENQ,
        S_WALK
    } t_state;

    typedef struct packed {
        logic [31:0] ticks;
        logic [15:0] handle;
        logic [31:0] arg;
    } t_entry;

endpackage

[rtl/tcq_if.sv]
interface tcq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] handle;
    logic signed [31:0] call_arg;
    logic [31:0] delay_us;

    modport source (output valid, cmd, handle, call_arg, delay_us, input ready);
    modport sink (input valid, cmd, handle, call_arg, delay_us, output ready);
endinterface

interface tcq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] fired_handle;
    logic signed [31:0] fired_arg;

    modport source (output valid, status, fired_handle, fired_arg, input ready);
    modport sink (input valid, status, fired_handle, fired_arg, output ready);
endinterface

[rtl/tick_callout_queue.sv]
// Callout queue: enqueue, tick and query requests each give one response
// (an unused command code gives none). Pending callouts sit in one
// dual-port RAM, kept packed in insertion order from entry 0 up. An enqueue
// converts the delay with a bit-serial divider. A tick or a query walks the
// live entries through the RAM at one per cycle; a tick rewrites each entry
// with its count decremented and closes the gap left by the fired callout in
// the same pass. One request is in flight at a time, and the next is taken
// once its response has left.
`include "tick_callout_queue_defines.svh"
module tick_callout_queue #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcq_req_if.sink     i_req,
    tcq_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $bits(t_entry);

    t_state          r_state, n_state;
    logic [31:0]     r_grain;
    logic [1:0]      r_cmd;
    logic [15:0]     r_handle;
    logic [31:0]     r_arg;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_wr, n_wr;
    logic            r_vld, n_vld;
    logic            r_hit, n_hit;
    logic [15:0]     r_fh, n_fh;
    logic [31:0]     r_fa, n_fa;
    logic            r_out_valid, n_out_valid;
    logic [2:0]      r_status, n_status;
    logic [15:0]     r_oh, n_oh;
    logic [31:0]     r_oa, n_oa;

    logic            req_acc;
    logic            full;
    logic            walk_end;
    logic            div_start;
    logic            div_done;
    logic [NUM_W-1:0] div_quot;
    logic [31:0]     grain1;
    logic [31:0]     ticks;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    t_entry          rd_entry;
    logic [EW-1:0]   ram_rdata;
    logic [31:0]     dec;

    assign full     = r_count == CW'(QUEUE_DEPTH);
    assign req_acc  = i_req.valid && i_req.ready;
    assign walk_end = (r_rd == r_count) && !r_vld;
    assign grain1   = (r_grain == '0) ? 32'd1 : r_grain;
    assign div_start = req_acc && (i_req.cmd == CMD_ENQ) && !full;
    assign rd_entry = t_entry'(ram_rdata);
    assign dec      = (rd_entry.ticks == '0) ? '0 : rd_entry.ticks - 1'b1;

    always_comb begin
        if (div_quot == '0) begin
            ticks = 32'd1;
        end else if (div_quot[NUM_W-1:32] != '0) begin
            ticks = 32'hFFFF_FFFF;
        end else begin
            ticks = div_quot[31:0];
        end
    end

    tcq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({1'b0, i_req.delay_us, 1'b0} + {2'b00, grain1}),
        .i_den   ({grain1, 1'b0}),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    tcq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    case (i_req.cmd)
                        CMD_ENQ:   n_state = full ? S_IDLE : S_DIV;
                        CMD_TICK:  n_state = (r_count == '0) ? S_IDLE : S_WALK;
                        CMD_QUERY: n_state = (r_count == '0) ? S_IDLE : S_WALK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV:   n_state = div_done ? S_ENQ : S_DIV;
            S_ENQ:   n_state = S_IDLE;
            S_WALK:  n_state = walk_end ? S_IDLE : S_WALK;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_vld       = 1'b0;
        n_hit       = r_hit;
        n_fh        = r_fh;
        n_fa        = r_fa;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_oh        = r_oh;
        n_oa        = r_oa;
        ram_we      = 1'b0;
        ram_waddr   = r_wr[AW-1:0];
        ram_wdata   = rd_entry;
        ram_wdata.ticks = dec;
        case (r_state)
            S_IDLE: begin
                n_rd  = '0;
                n_wr  = '0;
                n_hit = 1'b0;
                if (req_acc) begin
                    n_oh = '0;
                    n_oa = '0;
                    case (i_req.cmd)
                        CMD_ENQ: begin
                            if (full) begin
                                n_out_valid = 1'b1;
                                n_status    = STS_FULL;
                            end
                        end
                        CMD_TICK: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = STS_NO_FIRE;
                            end
                        end
                        CMD_QUERY: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = STS_NOT_FOUND;
                            end
                        end
                        default: n_out_valid = r_out_valid;
                    endcase
                end
            end
            S_DIV: begin
                n_hit = 1'b0;
            end
            S_ENQ: begin
                ram_we          = 1'b1;
                ram_waddr       = r_count[AW-1:0];
                ram_wdata.ticks  = ticks;
                ram_wdata.handle = r_handle;
                ram_wdata.arg    = r_arg;
                n_count         = r_count + 1'b1;
                n_out_valid     = 1'b1;
                n_status        = STS_ENQUEUED;
            end
            S_WALK: begin
                if (r_rd != r_count) begin
                    n_rd  = r_rd + 1'b1;
                    n_vld = 1'b1;
                end
                if (r_vld) begin
                    if (r_cmd == CMD_TICK) begin
                        if (dec == '0 && !r_hit) begin
                            n_hit = 1'b1;
                            n_fh  = rd_entry.handle;
                            n_fa  = rd_entry.arg;
                        end else begin
                            ram_we = 1'b1;
                            n_wr   = r_wr + 1'b1;
                        end
                    end else if (rd_entry.handle == r_handle) begin
                        n_hit = 1'b1;
                    end
                end
                if (walk_end) begin
                    n_out_valid = 1'b1;
                    if (r_cmd == CMD_TICK) begin
                        n_status = r_hit ? STS_FIRED : STS_NO_FIRE;
                        n_oh     = r_hit ? r_fh : '0;
                        n_oa     = r_hit ? r_fa : '0;
                        n_count  = r_hit ? r_count - 1'b1 : r_count;
                    end else begin
                        n_status = r_hit ? STS_FOUND : STS_NOT_FOUND;
                    end
                end
            end
            default: n_out_valid = r_out_valid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grain     <= GRAIN_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_vld       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_vld       <= n_vld;
            if (psel && penable && pwrite && !paddr[2]) begin
                r_grain <= pwdata;
            end
        end
        if (req_acc) begin
            r_cmd    <= i_req.cmd;
            r_handle <= i_req.handle;
            r_arg    <= i_req.call_arg;
        end
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_hit    <= n_hit;
        r_fh     <= n_fh;
        r_fa     <= n_fa;
        r_status <= n_status;
        r_oh     <= n_oh;
        r_oa     <= n_oa;
    end

    assign i_req.ready        = (r_state == S_IDLE) && !r_out_valid;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.fired_handle = r_oh;
    assign o_rsp.fired_arg    = r_oa;
    assign prdata             = paddr[2] ? '0 : r_grain;
    assign pready             = 1'b1;

    `TCQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `TCQ_ASSERT_IMP(a_ready_clear, i_clk, i_rst_n, i_req.ready, !o_rsp.valid)
    `TCQ_ASSERT_IMP(a_write_state, i_clk, i_rst_n, ram_we,
        (r_state == S_WALK) || (r_state == S_ENQ))
    `TCQ_ASSERT_IMP(a_compact, i_clk, i_rst_n, (r_state == S_WALK) && r_vld, r_wr < r_rd)
    `TCQ_ASSERT_NXT(a_div_enq, i_clk, i_rst_n, (r_state == S_DIV) && div_done,
        r_state == S_ENQ)
endmodule

[rtl/tcq_ram.sv]
module tcq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/tcq_div.sv]
module tcq_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tcq_pkg::NUM_W-1:0] i_num,
    input  logic [tcq_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [tcq_pkg::NUM_W-1:0] o_quot
);
    import tcq_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_q, n_q;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [NUM_W-1:0]  rem_s;
    logic [NUM_W-1:0]  diff;
    logic              ge;

    always_comb begin
        rem_s  = {r_rem, r_q[NUM_W-1]};
        diff   = rem_s - {1'b0, r_den};
        ge     = rem_s >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = ITER_W'(NUM_W);
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? diff[DEN_W-1:0] : rem_s[DEN_W-1:0];
            n_q   = {r_q[NUM_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[verif/tick_callout_queue_test.sv]
module tick_callout_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcq_pkg::*;

    localparam int POOL_SLOTS = 128;
    localparam int WALK_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    int err_count = 0;
    int hold_cycles = 0;
    int rsp_seen = 0;
    int rsp_handled = 0;
    bit rsp_burst = 1'b0;
    bit req_burst;
    logic [31:0] grain_now;
    logic [15:0] recent_handles[$];

    tcq_req_if req();
    tcq_rsp_if rsp();

    tick_callout_queue DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    typedef struct {
        t_status     status;
        logic [15:0] handle;
        logic [31:0] arg;
    } t_outcome;

    class callout_scoreboard;
        t_entry      pending[$];
        t_outcome    outcomes[$];
        logic [31:0] grain;

        function new();
            grain = GRAIN_RESET;
        endfunction

        function logic [31:0] to_ticks(logic [31:0] delay);
            logic [63:0] g;
            logic [63:0] t;
            g = (grain == 0) ? 64'd1 : {32'd0, grain};
            t = (2 * {32'd0, delay} + g) / (2 * g);
            if (t == 0) t = 1;
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            return t[31:0];
        endfunction

        function void note(t_cmd cmd, logic [15:0] h, logic [31:0] a, logic [31:0] d);
            t_outcome o;
            t_entry e;
            int fire;
            o.status = STS_NO_FIRE;
            o.handle = 0;
            o.arg = 0;
            case (cmd)
                CMD_ENQ: begin
                    if (pending.size() >= POOL_SLOTS) begin
                        o.status = STS_FULL;
                    end else begin
                        e.ticks = to_ticks(d);
                        e.handle = h;
                        e.arg = a;
                        pending.push_back(e);
                        o.status = STS_ENQUEUED;
                    end
                end
                CMD_TICK: begin
                    fire = -1;
                    foreach (pending[i]) begin
                        if (pending[i].ticks != 0) pending[i].ticks--;
                        if (pending[i].ticks == 0 && fire < 0) fire = i;
                    end
                    if (fire >= 0) begin
                        o.status = STS_FIRED;
                        o.handle = pending[fire].handle;
                        o.arg = pending[fire].arg;
                        pending.delete(fire);
                    end
                end
                CMD_QUERY: begin
                    o.status = STS_NOT_FOUND;
                    foreach (pending[i]) begin
                        if (pending[i].handle == h) o.status = STS_FOUND;
                    end
                end
                default: return;
            endcase
            outcomes.push_back(o);
        endfunction

        task check(logic [2:0] st, logic [15:0] h, logic [31:0] a);
            t_outcome o;
            if (outcomes.size() == 0) begin
                report("unexpected response status", st, 0);
                return;
            end
            o = outcomes.pop_front();
            if (st !== o.status) report("status", st, o.status);
            if (h !== o.handle) report("fired_handle", h, o.handle);
            if (a !== o.arg) report("fired_arg", a, o.arg);
        endtask
    endclass

    callout_scoreboard sb;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // response side
    always @(negedge i_clk) begin
        if (rsp_seen != rsp_handled) begin
            rsp_handled = rsp_seen;
            if (rsp_seen % 50 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
            if (rsp_seen == 300) hold_cycles = 2000;
            else if (rsp_burst) hold_cycles = 0;
            else hold_cycles = $urandom_range(0, 9);
        end
        if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            rsp.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready) begin
            sb.check(rsp.status, rsp.fired_handle, rsp.fired_arg);
            rsp_seen++;
        end
    end

    task automatic send(input t_cmd cmd, input logic [15:0] h, input logic [31:0] a,
                        input logic [31:0] d);
        int gap;
        gap = req_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.valid = 1'b1;
        req.cmd = cmd;
        req.handle = h;
        req.call_arg = a;
        req.delay_us = d;
        do @(posedge i_clk); while (!req.ready);
        sb.note(cmd, h, a, d);
        if (cmd == CMD_ENQ) begin
            recent_handles.push_back(h);
            if (recent_handles.size() > 16) void'(recent_handles.pop_front());
        end
        @(negedge i_clk);
    endtask

    task automatic settle();
        req.valid = 1'b0;
        while (sb.outcomes.size() != 0) @(negedge i_clk);
        repeat (WALK_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_grain(input logic [31:0] value);
        settle();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 3'd0;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        sb.grain = value;
        grain_now = value;
    endtask

    task automatic random_item();
        int pick;
        int sel;
        logic [15:0] h;
        logic [31:0] a;
        logic [31:0] d;
        logic [63:0] g;
        logic [63:0] dl;
        pick = $urandom_range(0, 99);
        a = $urandom;
        h = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        g = (grain_now == 0) ? 64'd1 : {32'd0, grain_now};
        sel = $urandom_range(0, 99);
        if (sel < 5) d = $urandom;
        else if (sel < 10) d = 0;
        else begin
            dl = g * $urandom_range(0, 6) + $urandom_range(0, 1000) % g;
            d = (dl > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dl[31:0];
        end
        if (pick < 40) send(CMD_ENQ, h, a, d);
        else if (pick < 80) send(CMD_TICK, h, a, d);
        else if (pick < 95) begin
            if (recent_handles.size() > 0 && $urandom_range(0, 1) == 0)
                h = recent_handles[$urandom_range(0, recent_handles.size() - 1)];
            send(CMD_QUERY, h, a, d);
        end else begin
            send(CMD_NONE, h, a, d);
        end
    endtask

    initial begin
        logic [31:0] grains[5];
        sb = new();
        req_burst = 1'b0;
        grain_now = GRAIN_RESET;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        req.valid = 1'b0;
        req.cmd = CMD_NONE;
        req.handle = 16'd0;
        req.call_arg = 32'sd0;
        req.delay_us = 32'd0;
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send(CMD_TICK, 16'h0, 32'h0, 32'h0);
        send(CMD_QUERY, 16'h0, 32'h0, 32'h0);
        send(CMD_ENQ, 16'h0000, 32'h8000_0000, 32'h0);
        send(CMD_ENQ, 16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_ENQ, 16'h0001, 32'hFFFF_FFFF, 32'd49999);
        send(CMD_ENQ, 16'h0001, 32'h1, 32'd50000);
        send(CMD_ENQ, 16'h0002, 32'h2, 32'd150000);
        send(CMD_QUERY, 16'hFFFF, 32'h0, 32'h0);
        send(CMD_QUERY, 16'h1234, 32'h0, 32'h0);
        send(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_TICK, 16'h0, 32'h0, 32'h0);
        send(CMD_TICK, 16'h0, 32'h0, 32'h0);
        send(CMD_TICK, 16'h0, 32'h0, 32'h0);
        send(CMD_TICK, 16'h0, 32'h0, 32'h0);
        send(CMD_QUERY, 16'h0001, 32'h0, 32'h0);

        grains[0] = 32'd1;
        grains[1] = 32'hFFFF_FFFF;
        grains[2] = 32'd0;
        grains[3] = $urandom_range(2, 5000);
        grains[4] = 32'd100000;
        foreach (grains[p]) begin
            write_grain(grains[p]);
            for (int n = 0; n < 250; n++) begin
                if (n % 40 == 0) req_burst = ($urandom_range(0, 3) == 0);
                random_item();
            end
        end

        // fill the pool and overflow it
        write_grain(32'd1);
        req_burst = 1'b0;
        for (int n = 0; n < POOL_SLOTS + 3; n++) send(CMD_ENQ, 16'($urandom), $urandom, $urandom);
        send(CMD_QUERY, 16'($urandom), 32'h0, 32'h0);
        send(CMD_TICK, 16'h0, 32'h0, 32'h0);
        send(CMD_ENQ, 16'hABCD, 32'h5, 32'h0);
        send(CMD_ENQ, 16'hABCD, 32'h5, 32'h0);

        settle();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
